// ===== src/sha_pkg.sv =====
`timescale 1ns / 1ps
package sha_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last;
    } sha_out_t;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } sha_state_t;

    // controller to datapath
    typedef struct packed {
        logic       wr_byte;
        logic       wr_pad;
        logic       clr_count;
        logic       round_init;
        logic       round_step;
        logic       fold;
        logic       reset_chain;
        logic [5:0] round_idx;
        logic [5:0] pad_idx;
        logic [2:0] out_idx;
    } sha_cmd_t;

    typedef struct packed {
        logic [5:0] pos;
    } sha_stat_t;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== src/sha_ctrl.sv =====
`timescale 1ns / 1ps
module sha_ctrl
    import sha_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_fire,
    input  logic      in_kind,
    output logic      s_ready,
    input  logic      out_busy,
    output logic      out_load,
    output logic      first_pad,
    input  sha_stat_t stat,
    output sha_cmd_t  cmd
);

    sha_state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       final_reg, final_next;   // this compression ends the message
    logic [3:0] emit_reg, emit_next;     // words still to hand over
    logic       pad_last_reg, pad_last_next;
    logic       pad_more_reg, pad_more_next;
    logic       first_pad_reg, first_pad_next;

    // pad fills from pos to 63; a block with room for the length is the last one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            final_reg <= 1'b0;
            emit_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            final_reg <= final_next;
            emit_reg  <= emit_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        final_next = final_reg;
        emit_next  = emit_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (in_kind == KIND_FINISH) begin
                        state_next = ST_PAD;
                        cnt_next   = stat.pos;
                        final_next = 1'b0;
                    end else if (stat.pos == 6'd63) begin
                        state_next = ST_ROUND;
                        cnt_next   = '0;
                        final_next = 1'b0;
                    end
                end
            end
            ST_PAD: begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    state_next = ST_ROUND;
                    final_next = pad_last_reg;
                end
            end
            ST_ROUND: begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) state_next = ST_FOLD;
            end
            ST_FOLD: begin
                cnt_next = '0;
                if (final_reg) begin
                    state_next = ST_EMIT;
                    emit_next  = 4'd8;
                end else if (pad_more_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!out_busy && emit_reg != 4'd0) begin
                    emit_next = emit_reg - 4'd1;
                    cnt_next  = cnt_reg + 6'd1;
                end
                if (emit_reg == 4'd0 && !out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // second pass of padding is needed when the marker lands past byte 55
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_last_reg <= 1'b0;
            pad_more_reg <= 1'b0;
        end else begin
            pad_last_reg <= pad_last_next;
            pad_more_reg <= pad_more_next;
        end
    end

    always_comb begin
        pad_last_next = pad_last_reg;
        pad_more_next = pad_more_reg;
        if (state_reg == ST_IDLE && in_fire && in_kind == KIND_FINISH) begin
            pad_last_next = (stat.pos < 6'd56);
            pad_more_next = (stat.pos >= 6'd56);
        end else if (state_reg == ST_FOLD && pad_more_reg) begin
            pad_last_next = 1'b1;
            pad_more_next = 1'b0;
        end
    end

    // marker byte goes in only on the first padding pass
    always_ff @(posedge aclk) begin
        if (!aresetn) first_pad_reg <= 1'b0;
        else          first_pad_reg <= first_pad_next;
    end
    always_comb begin
        first_pad_next = first_pad_reg;
        if (state_reg == ST_IDLE && in_fire && in_kind == KIND_FINISH)
            first_pad_next = 1'b1;
        else if (state_reg == ST_PAD && cnt_reg == 6'd63)
            first_pad_next = 1'b0;
    end

    assign first_pad = first_pad_reg;

    always_comb begin
        cmd         = '0;
        s_ready     = 1'b0;
        out_load    = 1'b0;
        cmd.round_idx = cnt_reg;
        cmd.pad_idx   = cnt_reg;
        cmd.out_idx   = cnt_reg[2:0];
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.wr_byte = in_fire && in_kind == KIND_DATA;
                cmd.round_init = in_fire && in_kind == KIND_DATA && stat.pos == 6'd63;
            end
            ST_PAD: begin
                cmd.wr_pad = 1'b1;
                cmd.round_init = (cnt_reg == 6'd63);
            end
            ST_ROUND: cmd.round_step = 1'b1;
            ST_FOLD:  cmd.fold = 1'b1;
            ST_EMIT: begin
                out_load = !out_busy && emit_reg != 4'd0;
                if (emit_reg == 4'd0 && !out_busy) begin
                    cmd.reset_chain = 1'b1;
                    cmd.clr_count   = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== src/sha_datapath.sv =====
`timescale 1ns / 1ps
module sha_datapath
    import sha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  in_byte,
    input  logic        first_pad,
    input  sha_cmd_t    cmd,
    output sha_stat_t   stat,
    output logic [31:0] word_out
);

    logic [31:0] blk_reg [16];
    logic [31:0] w_reg [16];
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [60:0] count_reg;

    assign stat.pos = count_reg[5:0];

    logic [63:0] bits;
    assign bits = {count_reg, 3'b000};

    logic pad_last_pass;
    assign pad_last_pass = !(first_pad && count_reg[5:0] >= 6'd56);

    // padding byte for position p
    logic [7:0] pad_byte;
    logic [5:0] p;
    assign p = cmd.pad_idx;
    always_comb begin
        if (first_pad && p == count_reg[5:0])
            pad_byte = 8'h80;
        else if (pad_last_pass && p >= 6'd56)
            pad_byte = bits[8*(7 - (p - 6'd56)) +: 8];
        else
            pad_byte = 8'h00;
    end

    logic [3:0] wsel;
    logic [1:0] bsel;
    assign wsel = cmd.wr_pad ? p[5:2] : count_reg[5:2];
    assign bsel = cmd.wr_pad ? p[1:0] : count_reg[1:0];

    always_ff @(posedge aclk) begin
        if (cmd.wr_byte || (cmd.wr_pad && (p >= count_reg[5:0] || !first_pad)))
            blk_reg[wsel][8*(3 - bsel) +: 8] <= cmd.wr_pad ? pad_byte : in_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr_count)
            count_reg <= '0;
        else if (cmd.wr_byte)
            count_reg <= count_reg + 61'd1;
    end

    // one round per cycle
    logic [31:0] wt, s0, s1, t1, t2, a, e;
    logic [5:0]  t;
    assign t = cmd.round_idx;
    always_comb begin
        s1 = rotr(w_reg[4'(t - 6'd2)], 17) ^ rotr(w_reg[4'(t - 6'd2)], 19)
           ^ (w_reg[4'(t - 6'd2)] >> 10);
        s0 = rotr(w_reg[4'(t - 6'd15)], 7) ^ rotr(w_reg[4'(t - 6'd15)], 18)
           ^ (w_reg[4'(t - 6'd15)] >> 3);
        wt = (t < 6'd16) ? blk_reg[t[3:0]]
           : s1 + w_reg[4'(t - 6'd7)] + s0 + w_reg[t[3:0]];
        a  = v_reg[0];
        e  = v_reg[4];
        t1 = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
           + ((e & v_reg[5]) ^ (~e & v_reg[6])) + ROUND_K[t] + wt;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
           + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge aclk) begin
        if (cmd.round_init) begin
            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
        end else if (cmd.round_step) begin
            w_reg[t[3:0]] <= wt;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= e;
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= a;
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.reset_chain) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= IV[i];
        end else if (cmd.fold) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
        end
    end

    assign word_out = h_reg[cmd.out_idx];

endmodule

// ===== src/sha256_hasher.sv =====
`timescale 1ns / 1ps
// sha256_hasher: SHA-256 digest of a byte stream
// s_ channel: one transfer per item, kind 0 carries a message byte,
// kind 1 ends the message and asks for the digest.
// m_ channel: eight transfers per message, digest words 0..7 with last on 7.
// the 64th byte of a block starts the round engine, 64 rounds at one per
// cycle plus a fold step, during which s_ready is low.
// a finish runs a padding sweep from the fill position pos to byte 63 and
// a compression; when fewer than nine bytes remain in the block a second
// sweep over the whole block and a compression follow.
// the digest words follow the last compression, one word per cycle while
// m_ready is high.
// a stalled receiver holds the word in the output register and the block
// waits with s_ready low; once the last word has left, the chain is back
// at the initial values and the length counter is clear.
// reset (aresetn low, synchronous) restores the initial hash values and
// clears the length; the block buffer and schedule need no reset.
module sha256_hasher
    import sha_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sha_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sha_out_t m_data
);

    sha_cmd_t  cmd;
    sha_stat_t stat;
    logic      out_load;
    logic      out_busy;
    logic      in_fire;
    logic      first_pad;
    logic [31:0] word_out;
    logic      valid_reg;
    sha_out_t  data_reg;

    assign in_fire  = s_valid && s_ready;
    assign out_busy = valid_reg && !m_ready;

    sha_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_kind   (s_data.kind),
        .s_ready   (s_ready),
        .out_busy  (out_busy),
        .out_load  (out_load),
        .first_pad (first_pad),
        .stat      (stat),
        .cmd       (cmd)
    );

    sha_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_byte   (s_data.data_byte),
        .first_pad (first_pad),
        .cmd       (cmd),
        .stat      (stat),
        .word_out  (word_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn)
            valid_reg <= 1'b0;
        else if (out_load)
            valid_reg <= 1'b1;
        else if (m_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            data_reg.digest_word <= word_out;
            data_reg.word_index  <= cmd.out_idx;
            data_reg.last        <= (cmd.out_idx == 3'd7);
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid)
        else $error("loaded word not presented");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_data) && m_valid))
        else $error("stalled word changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid && !m_ready && out_load))
        else $error("load while stalled");

endmodule

// ===== test/sha256_hasher_tb.sv =====
`timescale 1ns / 1ps
module sha256_hasher_tb;
    import sha_pkg::*;

    class digest_board;
        logic [31:0] chain[8];
        logic [7:0]  blk[64];
        logic [60:0] nbytes;
        sha_out_t    pending[$];
        int          errors;

        function void restart();
            for (int i = 0; i < 8; i++) chain[i] = IV[i];
            nbytes = '0;
        endfunction

        function logic [31:0] ror(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] v[8];
            logic [31:0] w[16];
            logic [31:0] wt, t1, t2, x2, x15;
            for (int i = 0; i < 8; i++) v[i] = chain[i];
            for (int t = 0; t < 64; t++) begin
                if (t < 16) begin
                    wt = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
                end else begin
                    x2 = w[(t-2) & 15];
                    x15 = w[(t-15) & 15];
                    wt = (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10)) + w[(t-7) & 15]
                       + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3)) + w[t & 15];
                end
                w[t & 15] = wt;
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + wt;
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) chain[i] += v[i];
        endfunction

        function void note_input(sha_in_t it);
            int p;
            logic [63:0] bits;
            sha_out_t r;
            p = int'(nbytes[5:0]);
            if (it.kind == KIND_DATA) begin
                blk[p] = it.data_byte;
                nbytes++;
                if (p == 63) compress();
                return;
            end
            bits = {nbytes, 3'b000};
            blk[p] = 8'h80;
            p++;
            if (p > 56) begin
                while (p < 64) begin
                    blk[p] = 8'h00;
                    p++;
                end
                compress();
                p = 0;
            end
            while (p < 56) begin
                blk[p] = 8'h00;
                p++;
            end
            for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
                r.digest_word = chain[i];
                r.word_index = i[2:0];
                r.last = (i == 7);
                pending = {pending, r};
            end
            restart();
        endfunction

        function void check_result(sha_out_t got);
            sha_out_t exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected digest word, actual %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.digest_word !== exp.digest_word) begin
                $display("%0t: digest_word expected %h actual %h",
                         $time, exp.digest_word, got.digest_word);
                errors++;
            end
            if (got.word_index !== exp.word_index) begin
                $display("%0t: word_index expected %0d actual %0d",
                         $time, exp.word_index, got.word_index);
                errors++;
            end
            if (got.last !== exp.last) begin
                $display("%0t: last expected %b actual %b", $time, exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic     aclk = 0;
    logic     aresetn = 0;
    logic     s_valid = 0;
    logic     s_ready;
    sha_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 0;
    sha_out_t m_data;

    digest_board board = new();
    int  cycles = 0;
    bit  calm = 0;
    bit  hold_sink = 0;

    sha256_hasher dut (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 1500000) begin
            $display("FAIL sha256_hasher");
            $finish;
        end
    end

    // receiver: random stall bursts, plus a long hold-off on request
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_sink) begin
                m_ready <= 0;
                for (int i = 0; i < 400; i++) @(posedge aclk);
                hold_sink = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 8);
                m_ready <= 0;
                repeat (gap) @(posedge aclk);
            end else begin
                m_ready <= 1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
    end

    task automatic send(logic k, logic [7:0] b);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_data <= '{kind: k, data_byte: b};
        s_valid <= 1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_input('{kind: k, data_byte: b});
    endtask

    task automatic message(int len, int style);
        for (int i = 0; i < len; i++) begin
            case (style)
                0: send(KIND_DATA, 8'h00);
                1: send(KIND_DATA, 8'hff);
                default: send(KIND_DATA, 8'($urandom));
            endcase
        end
        send(KIND_FINISH, 8'($urandom));
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int sent;
        int len;
        board.restart();
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // empty message, finish with all ignored bits set, zero and ones bytes
        send(KIND_FINISH, 8'hff);
        message(1, 0);
        message(3, 1);
        // length right at the one-block and two-block padding boundary
        message(55, 2);
        message(56, 2);

        // long receiver hold-off while the sender keeps going
        hold_sink = 1;
        message(2, 2);
        message(0, 2);
        message(1, 1);
        drain();
        message(64, 2);

        sent = 191;
        while (sent < 420) begin
            if (sent > 340) calm = 1;
            case ($urandom_range(0, 3))
                0: len = $urandom_range(0, 8);
                1: len = $urandom_range(52, 72);
                2: len = $urandom_range(0, 30);
                default: len = $urandom_range(100, 130);
            endcase
            if (len > 419 - sent) len = 419 - sent;
            message(len, $urandom_range(0, 5));
            sent += len + 1;
            if ($urandom_range(0, 5) == 0) drain();
        end
        drain();
        repeat (200) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("PASS sha256_hasher");
        end else begin
            $display("FAIL sha256_hasher");
        end
        $finish;
    end
endmodule

// ===== sha256_hasher.f =====
src/sha_pkg.sv
src/sha_ctrl.sv
src/sha_datapath.sv
src/sha256_hasher.sv
test/sha256_hasher_tb.sv
